// ===== sv/sdv3_pkg.sv =====
// ----------------------------------------------------------------------------
// sdv3_pkg
// Types and helpers for the critically damped vec3 smoother.
// ----------------------------------------------------------------------------
package sdv3_pkg;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
    } src_beat_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] vel_out_x;
        logic signed [31:0] vel_out_y;
        logic signed [31:0] vel_out_z;
    } res_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    localparam logic [1:0] REG_SMOOTH_TIME = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_DELTA_TIME  = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'(S32_MAX))
            r = S32_MAX;
        else if (v < 66'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/smooth_damp_vec3_unit.sv =====
// ----------------------------------------------------------------------------
// smooth_damp_vec3_unit
// Critically damped smoothing of a 3D position, one shared multiplier and
// one shared restoring divider under a step sequencer.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | beat
//  --------+----------------------------------+------------------------------
//  src     | src_valid, src_stall, src_data   | current and goal position
//  res     | res_valid, res_stall, res_data   | smoothed position, velocity
//  cfg     | cfg_we, cfg_addr, cfg_wdata      | register write, no wait
//
//  The divider quotient is QW = max(2*FRAC_BITS+2, 32) bits wide. The two
//  divisions (omega and decay) run one quotient bit per cycle in the shared
//  divider; the rest are steps of at most one multiply each.
//  src_stall is high from acceptance until the result beat is taken.
//  Reset clears control, the registers to their defaults and the velocities.
//  res_data holds while res_stall is high.
//
module smooth_damp_vec3_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  sdv3_pkg::src_beat_t  src_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output sdv3_pkg::res_beat_t  res_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [30:0]          cfg_wdata
);

    // fixed-point constants
    localparam longint ONE_L   = longint'(1) << FRAC_BITS;
    localparam longint FLOOR_L = (ONE_L + 9999) / 10000;
    localparam longint C48_L   = (48 * ONE_L + 50) / 100;
    localparam longint C235_L  = (235 * ONE_L + 500) / 1000;
    localparam int     QW      = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
    localparam int     CW      = $clog2(QW);

    localparam logic [30:0] FLOOR_T = 31'(FLOOR_L);

    // sequencer steps
    localparam logic [4:0] SP_OMEGA = 5'd0;
    localparam logic [4:0] SP_X     = 5'd1;
    localparam logic [4:0] SP_X2    = 5'd2;
    localparam logic [4:0] SP_X3    = 5'd3;
    localparam logic [4:0] SP_P48   = 5'd4;
    localparam logic [4:0] SP_P235  = 5'd5;
    localparam logic [4:0] SP_DEN   = 5'd6;
    localparam logic [4:0] SP_DIV2  = 5'd7;
    localparam logic [4:0] SP_DECAY = 5'd8;
    localparam logic [4:0] SP_CHG   = 5'd9;
    localparam logic [4:0] SP_TVAL  = 5'd10;
    localparam logic [4:0] SP_A     = 5'd11;
    localparam logic [4:0] SP_TEMP  = 5'd12;
    localparam logic [4:0] SP_M2    = 5'd13;
    localparam logic [4:0] SP_B     = 5'd14;
    localparam logic [4:0] SP_NV    = 5'd15;
    localparam logic [4:0] SP_M3    = 5'd16;
    localparam logic [4:0] SP_WR    = 5'd17;

    sdv3_pkg::state_t    state_reg, state_next;
    logic [4:0]          step_reg, step_next;
    logic [1:0]          ax_reg, ax_next;
    logic [30:0]         st_reg, st_next;
    logic [30:0]         ms_reg, ms_next;
    logic [30:0]         dt_reg, dt_next;
    sdv3_pkg::src_beat_t in_reg, in_next;
    sdv3_pkg::res_beat_t res_reg, res_next;
    logic [30:0]         lt_reg, lt_next;
    logic signed [31:0]  omega_reg, omega_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  x2_reg, x2_next;
    logic signed [31:0]  x3_reg, x3_next;
    logic signed [31:0]  den_reg, den_next;
    logic signed [31:0]  decay_reg, decay_next;
    logic signed [31:0]  maxc_reg, maxc_next;
    logic signed [31:0]  chg_reg, chg_next;
    logic signed [31:0]  tval_reg, tval_next;
    logic signed [31:0]  tmp_reg, tmp_next;
    logic signed [31:0]  s_reg, s_next;
    logic signed [31:0]  c_reg, c_next;
    logic signed [31:0]  p_reg, p_next;
    logic signed [31:0]  nv_reg, nv_next;
    logic signed [31:0]  vel_reg [3];
    logic signed [31:0]  vel_next [3];
    logic [30:0]         dden_reg, dden_next;
    logic [31:0]         rem_reg, rem_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    // shared multiplier: 33x33 signed, floor shift, saturate
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_prod;
    logic signed [31:0]  mul_q;

    // divider datapath
    logic [32:0]         trial;
    logic                take;
    logic signed [31:0]  div_q;

    // per-axis operands
    logic signed [31:0]  cur_s, goal_s, vel_s;
    logic signed [31:0]  diff, out_n;
    logic signed [32:0]  gd;
    logic                overshoot;

    assign mul_prod = mul_a * mul_b;
    assign mul_q    = sdv3_pkg::sat32(mul_prod >>> FRAC_BITS);

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign take  = trial >= {2'b00, dden_reg};
    assign div_q = (|quo_reg[QW-1:31]) ? sdv3_pkg::S32_MAX : $signed({1'b0, quo_reg[30:0]});

    always_comb
    begin
        case (ax_reg)
            2'd0:
            begin
                cur_s  = in_reg.cur_x;
                goal_s = in_reg.goal_x;
            end
            2'd1:
            begin
                cur_s  = in_reg.cur_y;
                goal_s = in_reg.goal_y;
            end
            default:
            begin
                cur_s  = in_reg.cur_z;
                goal_s = in_reg.goal_z;
            end
        endcase
        vel_s = (ax_reg == 2'd0) ? vel_reg[0] : (ax_reg == 2'd1) ? vel_reg[1] : vel_reg[2];
    end

    // operand select for the multiplier by step
    always_comb
    begin
        case (step_reg)
            SP_X:
            begin
                mul_a = {omega_reg[31], omega_reg};
                mul_b = $signed({2'b00, dt_reg});
            end
            SP_X2:
            begin
                mul_a = {x_reg[31], x_reg};
                mul_b = {x_reg[31], x_reg};
            end
            SP_X3:
            begin
                mul_a = {x2_reg[31], x2_reg};
                mul_b = {x_reg[31], x_reg};
            end
            SP_P48:
            begin
                mul_a = $signed(33'(C48_L));
                mul_b = {x2_reg[31], x2_reg};
            end
            SP_P235:
            begin
                mul_a = $signed(33'(C235_L));
                mul_b = {x3_reg[31], x3_reg};
            end
            SP_DECAY:
            begin
                mul_a = $signed({2'b00, ms_reg});
                mul_b = $signed({2'b00, lt_reg});
            end
            SP_TVAL:
            begin
                mul_a = {omega_reg[31], omega_reg};
                mul_b = {chg_reg[31], chg_reg};
            end
            SP_TEMP:
            begin
                mul_a = {s_reg[31], s_reg};
                mul_b = $signed({2'b00, dt_reg});
            end
            SP_M2:
            begin
                mul_a = {omega_reg[31], omega_reg};
                mul_b = {tmp_reg[31], tmp_reg};
            end
            SP_NV:
            begin
                mul_a = {s_reg[31], s_reg};
                mul_b = {decay_reg[31], decay_reg};
            end
            SP_M3:
            begin
                mul_a = {c_reg[31], c_reg};
                mul_b = {decay_reg[31], decay_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        // clamp of the distance, overshoot test
        diff = sdv3_pkg::sat32(66'(cur_s) - 66'(goal_s));
        if (diff > maxc_reg)
            diff = maxc_reg;
        if (diff < -maxc_reg)
            diff = -maxc_reg;
        out_n     = sdv3_pkg::sat32(66'(tval_reg) + 66'(p_reg));
        gd        = 33'(goal_s) - 33'(cur_s);
        overshoot = (gd > 33'sd0) == (out_n > goal_s);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ax_next    = ax_reg;
        st_next    = st_reg;
        ms_next    = ms_reg;
        dt_next    = dt_reg;
        in_next    = in_reg;
        res_next   = res_reg;
        lt_next    = lt_reg;
        omega_next = omega_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        x3_next    = x3_reg;
        den_next   = den_reg;
        decay_next = decay_reg;
        maxc_next  = maxc_reg;
        chg_next   = chg_reg;
        tval_next  = tval_reg;
        tmp_next   = tmp_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        nv_next    = nv_reg;
        vel_next   = vel_reg;
        dden_next  = dden_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                sdv3_pkg::REG_SMOOTH_TIME: st_next = cfg_wdata;
                sdv3_pkg::REG_MAX_SPEED:   ms_next = cfg_wdata;
                sdv3_pkg::REG_DELTA_TIME:  dt_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            sdv3_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    in_next    = src_data;
                    lt_next    = (st_reg < FLOOR_T) ? FLOOR_T : st_reg;
                    dden_next  = (st_reg < FLOOR_T) ? FLOOR_T : st_reg;
                    rem_next   = '0;
                    quo_next   = QW'(1) << (2 * FRAC_BITS + 1);
                    cnt_next   = '0;
                    step_next  = SP_OMEGA;
                    state_next = sdv3_pkg::ST_DIV;
                end
            end
            sdv3_pkg::ST_DIV:
            begin
                rem_next = take ? 32'(trial - {2'b00, dden_reg}) : trial[31:0];
                quo_next = {quo_reg[QW-2:0], take};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                    state_next = sdv3_pkg::ST_CALC;
            end
            sdv3_pkg::ST_CALC:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    SP_OMEGA: omega_next = div_q;
                    SP_X:     x_next = mul_q;
                    SP_X2:
                    begin
                        x2_next  = mul_q;
                        den_next = sdv3_pkg::sat32($signed(66'(ONE_L)) + 66'(x_reg));
                    end
                    SP_X3:    x3_next = mul_q;
                    SP_P48:   p_next = mul_q;
                    SP_P235:
                    begin
                        den_next = sdv3_pkg::sat32(66'(den_reg) + 66'(p_reg));
                        p_next   = mul_q;
                    end
                    SP_DEN:   den_next = sdv3_pkg::sat32(66'(den_reg) + 66'(p_reg));
                    SP_DIV2:
                    begin
                        dden_next  = den_reg[30:0];
                        rem_next   = '0;
                        quo_next   = QW'(1) << (2 * FRAC_BITS);
                        cnt_next   = '0;
                        state_next = sdv3_pkg::ST_DIV;
                    end
                    SP_DECAY:
                    begin
                        decay_next = div_q;
                        maxc_next  = mul_q;
                        ax_next    = 2'd0;
                    end
                    SP_CHG:   chg_next = diff;
                    SP_TVAL:
                    begin
                        tval_next = sdv3_pkg::sat32(66'(cur_s) - 66'(chg_reg));
                        p_next    = mul_q;
                    end
                    SP_A:     s_next = sdv3_pkg::sat32(66'(vel_s) + 66'(p_reg));
                    SP_TEMP:  tmp_next = mul_q;
                    SP_M2:
                    begin
                        p_next = mul_q;
                        c_next = sdv3_pkg::sat32(66'(chg_reg) + 66'(tmp_reg));
                    end
                    SP_B:     s_next = sdv3_pkg::sat32(66'(vel_s) - 66'(p_reg));
                    SP_NV:    nv_next = mul_q;
                    SP_M3:    p_next = mul_q;
                    SP_WR:
                    begin
                        // past the goal: snap to it and stop
                        case (ax_reg)
                            2'd0:
                            begin
                                res_next.out_x     = overshoot ? goal_s : out_n;
                                res_next.vel_out_x = overshoot ? '0 : nv_reg;
                                vel_next[0]        = overshoot ? '0 : nv_reg;
                            end
                            2'd1:
                            begin
                                res_next.out_y     = overshoot ? goal_s : out_n;
                                res_next.vel_out_y = overshoot ? '0 : nv_reg;
                                vel_next[1]        = overshoot ? '0 : nv_reg;
                            end
                            default:
                            begin
                                res_next.out_z     = overshoot ? goal_s : out_n;
                                res_next.vel_out_z = overshoot ? '0 : nv_reg;
                                vel_next[2]        = overshoot ? '0 : nv_reg;
                            end
                        endcase
                        if (ax_reg == 2'd2)
                        begin
                            state_next = sdv3_pkg::ST_OUT;
                        end
                        else
                        begin
                            ax_next   = ax_reg + 1'b1;
                            step_next = SP_CHG;
                        end
                    end
                    default: ;
                endcase
            end
            sdv3_pkg::ST_OUT:
            begin
                if (!res_stall)
                    state_next = sdv3_pkg::ST_IDLE;
            end
            default: state_next = sdv3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdv3_pkg::ST_IDLE;
            step_reg  <= SP_OMEGA;
            ax_reg    <= 2'd0;
            cnt_reg   <= '0;
            st_reg    <= 31'd6554;
            ms_reg    <= 31'h7FFF_FFFF;
            dt_reg    <= 31'd1092;
            vel_reg   <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ax_reg    <= ax_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            ms_reg    <= ms_next;
            dt_reg    <= dt_next;
            vel_reg   <= vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        res_reg   <= res_next;
        lt_reg    <= lt_next;
        omega_reg <= omega_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        x3_reg    <= x3_next;
        den_reg   <= den_next;
        decay_reg <= decay_next;
        maxc_reg  <= maxc_next;
        chg_reg   <= chg_next;
        tval_reg  <= tval_next;
        tmp_reg   <= tmp_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        p_reg     <= p_next;
        nv_reg    <= nv_next;
        dden_reg  <= dden_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign src_stall = state_reg != sdv3_pkg::ST_IDLE;
    assign res_valid = state_reg == sdv3_pkg::ST_OUT;
    assign res_data  = res_reg;

endmodule
